@@ hw/rtl/hsv_histogram_accumulator_defines.svh @@
// Assertion macros for the HSV histogram accumulator.
// Each module that asserts includes this file; the macros expect i_clk and i_rst_n in scope.
`ifndef HSV_HISTOGRAM_ACCUMULATOR_DEFINES_SVH
`define HSV_HISTOGRAM_ACCUMULATOR_DEFINES_SVH

// Check that the condition implies the consequence in the same cycle.
`define HSVHA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsv histogram: same-cycle check failed");

// Check that the condition implies the consequence in the next cycle.
`define HSVHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsv histogram: next-cycle check failed");

`endif

@@ hw/rtl/hsvha_pkg.sv @@
// Shared types, constants and the bin scaling function for the HSV histogram accumulator.
// No dependencies.
package hsvha_pkg;

    localparam int HUE_BINS   = 10;
    localparam int SAT_BINS   = 10;
    localparam int VAL_BINS   = 10;
    localparam int COLOR_BINS = HUE_BINS * SAT_BINS;
    localparam int NBINS      = COLOR_BINS + VAL_BINS;

    localparam int FRAC_W  = 16;
    localparam int IDX_W   = 7;
    localparam int CNT_W   = 32;
    localparam int BIN_W   = 6;
    localparam int NB_W    = 7;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [FRAC_W-1:0] SAT_THR_RST = 16'd6554;
    localparam logic [FRAC_W-1:0] VAL_THR_RST = 16'd13107;

    localparam logic [KIND_W-1:0] KIND_ACC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SAT_THR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_THR = 1'b1;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic capture;
        logic index;
        logic read;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    // Map a Q0.16 fraction onto one of nbins bins, clamped to the top bin.
    function automatic logic [BIN_W-1:0] scale_bin(input logic [FRAC_W-1:0] frac,
                                                   input logic [NB_W-1:0] nbins);
        logic [FRAC_W+NB_W-1:0] prod;
        logic [NB_W-1:0]        top;
        logic [NB_W-1:0]        last;
        prod = (FRAC_W+NB_W)'(frac) * (FRAC_W+NB_W)'(nbins);
        top  = prod[FRAC_W+NB_W-1:FRAC_W];
        last = nbins - NB_W'(1);
        if (top > last) begin
            top = last;
        end
        return BIN_W'(top);
    endfunction

endpackage

@@ hw/rtl/hsvha_ctrl.sv @@
// Sequencer for the HSV histogram accumulator: capture, index, read, commit.
// Depends on hsvha_pkg and the assertion macros header.
`include "hsv_histogram_accumulator_defines.svh"

module hsvha_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  hsvha_pkg::t_status i_status,
    output hsvha_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.capture = i_s_valid;
                if (i_s_valid) begin
                    n_state = ST_INDEX;
                end
            end
            ST_INDEX: begin
                o_cmd.index = 1'b1;
                n_state     = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_WRITE;
            end
            ST_WRITE: begin
                // hold until the output register can take the result
                o_cmd.commit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `HSVHA_ASSERT_NEXT(a_capture_to_index, o_cmd.capture, r_state == ST_INDEX)
    `HSVHA_ASSERT_NEXT(a_commit_frees_input, o_cmd.commit, o_s_ready)
    `HSVHA_ASSERT_NEXT(a_stall_holds_write, (r_state == ST_WRITE) && !i_status.out_free,
                       (r_state == ST_WRITE) && !o_s_ready)

endmodule

@@ hw/rtl/hsvha_dp.sv @@
// Datapath of the HSV histogram accumulator: thresholds, bin mapping, count store, output register.
// Depends on hsvha_pkg and the assertion macros header; driven by hsvha_ctrl commands.
`include "hsv_histogram_accumulator_defines.svh"

module hsvha_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hsvha_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hsvha_pkg::FRAC_W-1:0]        i_cfg_wdata,
    input  logic [hsvha_pkg::S_TDATA_W-1:0]     i_s_data,
    input  logic [hsvha_pkg::KIND_W-1:0]        i_s_kind,
    input  hsvha_pkg::t_cmd                     i_cmd,
    output hsvha_pkg::t_status                  o_status,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [hsvha_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser
);

    localparam int IDX_W  = hsvha_pkg::IDX_W;
    localparam int BIN_W  = hsvha_pkg::BIN_W;
    localparam int CNT_W  = hsvha_pkg::CNT_W;
    localparam int FRAC_W = hsvha_pkg::FRAC_W;

    logic [FRAC_W-1:0] r_sat_thr;
    logic [FRAC_W-1:0] r_val_thr;

    logic [hsvha_pkg::KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]             r_read_index;
    logic [BIN_W-1:0]             r_hue_bin;
    logic [BIN_W-1:0]             r_sat_bin;
    logic [BIN_W-1:0]             r_val_bin;
    logic                         r_cless;
    logic [IDX_W-1:0]             r_idx;
    logic                         r_hit;
    logic [CNT_W-1:0]             r_rd_data;
    logic [hsvha_pkg::NBINS-1:0]  r_valid;
    logic [CNT_W-1:0]             r_mem [hsvha_pkg::NBINS];

    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [CNT_W-1:0] r_out_cnt;
    logic             r_out_cless;

    logic [FRAC_W-1:0] s_hue;
    logic [FRAC_W-1:0] s_sat;
    logic [FRAC_W-1:0] s_val;
    logic [IDX_W-1:0]  s_ridx;
    logic [IDX_W-1:0]  n_idx;
    logic              idx_in_range;
    logic [CNT_W-1:0]  base_cnt;
    logic [CNT_W-1:0]  upd_cnt;
    logic              do_write;

    assign s_hue  = i_s_data[FRAC_W-1:0];
    assign s_sat  = i_s_data[2*FRAC_W-1:FRAC_W];
    assign s_val  = i_s_data[3*FRAC_W-1:2*FRAC_W];
    assign s_ridx = i_s_data[3*FRAC_W+IDX_W-1:3*FRAC_W];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_thr <= hsvha_pkg::SAT_THR_RST;
            r_val_thr <= hsvha_pkg::VAL_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hsvha_pkg::REG_SAT_THR: r_sat_thr <= i_cfg_wdata;
                hsvha_pkg::REG_VAL_THR: r_val_thr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // capture: bin each component and classify the pixel
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind       <= i_s_kind;
            r_read_index <= s_ridx;
            r_hue_bin    <= hsvha_pkg::scale_bin(s_hue, hsvha_pkg::NB_W'(hsvha_pkg::HUE_BINS));
            r_sat_bin    <= hsvha_pkg::scale_bin(s_sat, hsvha_pkg::NB_W'(hsvha_pkg::SAT_BINS));
            r_val_bin    <= hsvha_pkg::scale_bin(s_val, hsvha_pkg::NB_W'(hsvha_pkg::VAL_BINS));
            r_cless      <= (s_sat < r_sat_thr) || (s_val < r_val_thr);
        end
    end

    always_comb begin
        if (r_kind == hsvha_pkg::KIND_READ) begin
            n_idx = r_read_index;
        end else if (r_cless) begin
            n_idx = IDX_W'(IDX_W'(hsvha_pkg::COLOR_BINS) + IDX_W'(r_val_bin));
        end else begin
            n_idx = IDX_W'(IDX_W'(r_sat_bin) * IDX_W'(hsvha_pkg::HUE_BINS)
                           + IDX_W'(r_hue_bin));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.index) begin
            r_idx <= n_idx;
        end
    end

    assign idx_in_range = (r_idx < IDX_W'(hsvha_pkg::NBINS));

    // count store read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_idx];
            r_hit     <= idx_in_range && r_valid[r_idx];
        end
    end

    assign base_cnt = r_hit ? r_rd_data : '0;
    assign upd_cnt  = (base_cnt == hsvha_pkg::COUNT_MAX) ? base_cnt : base_cnt + CNT_W'(1);
    assign do_write = i_cmd.commit && (r_kind == hsvha_pkg::KIND_ACC) && idx_in_range;

    // count store write port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_idx] <= upd_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit && (r_kind == hsvha_pkg::KIND_CLEAR)) begin
            r_valid <= '0;
        end else if (do_write) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            unique case (r_kind)
                hsvha_pkg::KIND_ACC: begin
                    r_out_idx   <= r_idx;
                    r_out_cnt   <= idx_in_range ? upd_cnt : '0;
                    r_out_cless <= r_cless;
                end
                hsvha_pkg::KIND_READ: begin
                    r_out_idx   <= r_idx;
                    r_out_cnt   <= base_cnt;
                    r_out_cless <= 1'b0;
                end
                default: begin
                    r_out_idx   <= '0;
                    r_out_cnt   <= '0;
                    r_out_cless <= 1'b0;
                end
            endcase
        end
    end

    assign o_status.out_free = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(hsvha_pkg::M_TDATA_W - IDX_W - CNT_W)'(0), r_out_cnt, r_out_idx};
    assign m_axis_tuser  = r_out_cless;

    `HSVHA_ASSERT_NEXT(a_clear_drops_valid,
                       i_cmd.commit && (r_kind == hsvha_pkg::KIND_CLEAR), r_valid == '0)
    `HSVHA_ASSERT_NEXT(a_accumulate_nonzero, do_write, r_out_valid && (r_out_cnt != '0))
    `HSVHA_ASSERT_NOW(a_commit_needs_room, i_cmd.commit, o_status.out_free)

endmodule

@@ hw/rtl/hsv_histogram_accumulator.sv @@
// HSV color histogram accumulator with colorless bins.
// Slave stream: s_axis_tuser carries the item kind (accumulate pixel, read bin, clear all);
// s_axis_tdata carries hue, saturation, value (Q0.16) and the bin to read.
// Master stream: one result per item, holding the bin index and its count after the item;
// m_axis_tuser marks a pixel that landed in a colorless bin.
// Configuration: i_cfg_we writes i_cfg_wdata to the saturation threshold (index 0)
// or the value threshold (index 1); write only while the block is idle.
// Timing: an item passes through the capture, index, read and update steps, and the next item is
// taken in the cycle after its result is loaded, so items never overlap. The
// read-modify-write of one bin through the count store (index, read, update) sets
// this pace.
// Reset (synchronous, active low) restores the default thresholds and marks every bin
// empty at once; the block is ready for an item as soon as reset is released.
// When the receiver stalls, the result waits in the output register; the next item is
// still taken and worked up to its update, where it holds until the register frees.
// Depends on hsvha_pkg, hsvha_ctrl and hsvha_dp.
module hsv_histogram_accumulator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hsvha_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hsvha_pkg::FRAC_W-1:0]        i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // hue [15:0], sat [31:16], val [47:32], read_index [54:48], zero [55]
    input  logic [hsvha_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // kind [1:0]
    input  logic [hsvha_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bin_index [6:0], bin_count [38:7], zero [39]
    output logic [hsvha_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // colorless [0]
    output logic                                m_axis_tuser
);

    hsvha_pkg::t_cmd    cmd;
    hsvha_pkg::t_status status;

    hsvha_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    hsvha_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_s_data      (s_axis_tdata),
        .i_s_kind      (s_axis_tuser),
        .i_cmd         (cmd),
        .o_status      (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ verif/tb_hsv_histogram_accumulator.sv @@
// Self-checking testbench for the HSV histogram accumulator: directed and random items
// against an in-bench histogram predictor, under several sender and receiver idle mixes.
// Depends on hsvha_pkg and hsv_histogram_accumulator.
`timescale 1ns / 1ps

module tb_hsv_histogram_accumulator;

    localparam int KIND_W     = hsvha_pkg::KIND_W;
    localparam int FRAC_W     = hsvha_pkg::FRAC_W;
    localparam int IDX_W      = hsvha_pkg::IDX_W;
    localparam int CNT_W      = hsvha_pkg::CNT_W;
    localparam int CFG_IDX_W  = hsvha_pkg::CFG_IDX_W;
    localparam int S_TDATA_W  = hsvha_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = hsvha_pkg::M_TDATA_W;
    localparam int NBINS      = hsvha_pkg::NBINS;
    localparam int COLOR_BINS = hsvha_pkg::COLOR_BINS;
    localparam int HUE_BINS   = hsvha_pkg::HUE_BINS;
    localparam int SAT_BINS   = hsvha_pkg::SAT_BINS;
    localparam int VAL_BINS   = hsvha_pkg::VAL_BINS;

    localparam logic [CNT_W-1:0]     COUNT_MAX   = hsvha_pkg::COUNT_MAX;
    localparam logic [KIND_W-1:0]    KIND_ACC    = hsvha_pkg::KIND_ACC;
    localparam logic [KIND_W-1:0]    KIND_READ   = hsvha_pkg::KIND_READ;
    localparam logic [KIND_W-1:0]    KIND_CLEAR  = hsvha_pkg::KIND_CLEAR;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_THR = hsvha_pkg::REG_SAT_THR;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_THR = hsvha_pkg::REG_VAL_THR;
    localparam logic [FRAC_W-1:0]    SAT_THR_RST = hsvha_pkg::SAT_THR_RST;
    localparam logic [FRAC_W-1:0]    VAL_THR_RST = hsvha_pkg::VAL_THR_RST;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 380;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FRAC_W-1:0] hue;
        logic [FRAC_W-1:0] sat;
        logic [FRAC_W-1:0] val;
        logic [IDX_W-1:0]  read_index;
    } t_hsv_item;

    typedef struct packed {
        logic [IDX_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_count;
        logic             colorless;
    } t_bin_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FRAC_W-1:0]    i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [KIND_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    // Predictor state: histogram copy and thresholds as the block should hold them.
    logic [CNT_W-1:0]  hist_count [NBINS];
    logic              hist_valid [NBINS];
    logic [FRAC_W-1:0] pred_sat_thr;
    logic [FRAC_W-1:0] pred_val_thr;

    t_bin_result expected_bins[$];
    t_hsv_item   last_pixel;
    int          errors;
    int          quiet_cycles;
    int          src_idle_pct;
    int          sink_stall_pct;

    hsv_histogram_accumulator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int frac_to_bin(input logic [FRAC_W-1:0] frac, input int nbins);
        int b;
        b = (int'(frac) * nbins) >> FRAC_W;
        if (b > nbins - 1) begin
            b = nbins - 1;
        end
        return b;
    endfunction

    // Apply one item to the histogram copy and return the result it should produce.
    function automatic t_bin_result histogram_step(input t_hsv_item it);
        t_bin_result r;
        int          idx;
        r = '0;
        case (it.kind)
            KIND_ACC: begin
                if (it.sat < pred_sat_thr || it.val < pred_val_thr) begin
                    idx = COLOR_BINS + frac_to_bin(it.val, VAL_BINS);
                    r.colorless = 1'b1;
                end else begin
                    idx = frac_to_bin(it.sat, SAT_BINS) * HUE_BINS
                        + frac_to_bin(it.hue, HUE_BINS);
                end
                r.bin_count = hist_valid[idx] ? hist_count[idx] : '0;
                if (r.bin_count != COUNT_MAX) begin
                    r.bin_count = r.bin_count + CNT_W'(1);
                end
                hist_count[idx] = r.bin_count;
                hist_valid[idx] = 1'b1;
                r.bin_index = IDX_W'(idx);
            end
            KIND_READ: begin
                r.bin_index = it.read_index;
                if (it.read_index < NBINS) begin
                    r.bin_count = hist_valid[it.read_index] ? hist_count[it.read_index] : '0;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < NBINS; i++) begin
                    hist_valid[i] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Predict on every input transfer, compare on every output transfer, run the watchdog.
    always @(posedge i_clk) begin : result_check
        t_hsv_item   seen;
        t_bin_result got;
        t_bin_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen.kind       = s_axis_tuser;
                seen.hue        = s_axis_tdata[15:0];
                seen.sat        = s_axis_tdata[31:16];
                seen.val        = s_axis_tdata[47:32];
                seen.read_index = s_axis_tdata[54:48];
                expected_bins.push_back(histogram_step(seen));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.bin_index = m_axis_tdata[6:0];
                got.bin_count = m_axis_tdata[38:7];
                got.colorless = m_axis_tuser;
                if (expected_bins.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual bin %0d count %0d",
                             $time, got.bin_index, got.bin_count);
                end else begin
                    want = expected_bins.pop_front();
                    if (got.bin_index !== want.bin_index) begin
                        errors++;
                        $display("%0t: bin_index expected %0d actual %0d",
                                 $time, want.bin_index, got.bin_index);
                    end
                    if (got.bin_count !== want.bin_count) begin
                        errors++;
                        $display("%0t: bin_count expected %0d actual %0d",
                                 $time, want.bin_count, got.bin_count);
                    end
                    if (got.colorless !== want.colorless) begin
                        errors++;
                        $display("%0t: colorless expected %0d actual %0d",
                                 $time, want.colorless, got.colorless);
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic t_hsv_item make_item(input logic [KIND_W-1:0] kind,
                                            input logic [FRAC_W-1:0] hue,
                                            input logic [FRAC_W-1:0] sat,
                                            input logic [FRAC_W-1:0] val,
                                            input logic [IDX_W-1:0]  read_index);
        t_hsv_item it;
        it.kind       = kind;
        it.hue        = hue;
        it.sat        = sat;
        it.val        = val;
        it.read_index = read_index;
        return it;
    endfunction

    // Mostly pixels, with repeats of the last pixel to hit the same bin back to back and
    // values close to the thresholds; reads, clears and the unused kind fill the rest.
    function automatic t_hsv_item random_item();
        t_hsv_item it;
        int        pick;
        it.hue        = FRAC_W'($urandom);
        it.sat        = FRAC_W'($urandom);
        it.val        = FRAC_W'($urandom);
        it.read_index = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(127))
                                                 : IDX_W'($urandom_range(NBINS - 1));
        pick = $urandom_range(99);
        if (pick < 76) begin
            it.kind = KIND_ACC;
            pick = $urandom_range(99);
            if (pick < 25) begin
                it = last_pixel;
            end else if (pick < 35) begin
                it.sat = pred_sat_thr - 16'd1 + FRAC_W'($urandom_range(2));
            end else if (pick < 45) begin
                it.val = pred_val_thr - 16'd1 + FRAC_W'($urandom_range(2));
            end
            last_pixel = it;
        end else if (pick < 94) begin
            it.kind = KIND_READ;
        end else if (pick < 97) begin
            it.kind = KIND_CLEAR;
        end else begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    // Leaves tvalid high after the transfer so the next item can follow without a gap.
    task automatic send_item(input t_hsv_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {1'b0, it.read_index, it.val, it.sat, it.hue};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_bins.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_thresholds(input logic [FRAC_W-1:0] sat_thr,
                                  input logic [FRAC_W-1:0] val_thr);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_SAT_THR;
        i_cfg_wdata <= sat_thr;
        @(posedge i_clk);
        i_cfg_index <= REG_VAL_THR;
        i_cfg_wdata <= val_thr;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pred_sat_thr = sat_thr;
        pred_val_thr = val_thr;
    endtask

    // Default thresholds: empty reads, reads past the last bin, corner pixels, threshold
    // edges, the unused kind, and clear followed by fresh counts.
    task automatic test_reset_defaults();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(make_item(KIND_READ, 16'h0000, 16'h0000, 16'h0000, 7'd0));
        send_item(make_item(KIND_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, IDX_W'(NBINS - 1)));
        send_item(make_item(KIND_READ, 16'h0000, 16'h0000, 16'h0000, IDX_W'(NBINS)));
        send_item(make_item(KIND_READ, 16'h0000, 16'h0000, 16'h0000, 7'h7F));
        send_item(make_item(KIND_ACC, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd0));
        send_item(make_item(KIND_ACC, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd0));
        send_item(make_item(KIND_ACC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F));
        send_item(make_item(KIND_ACC, 16'h0000, SAT_THR_RST - 16'd1, 16'hFFFF, 7'd0));
        send_item(make_item(KIND_ACC, 16'h8000, SAT_THR_RST, VAL_THR_RST, 7'd0));
        send_item(make_item(KIND_ACC, 16'h8000, 16'hFFFF, VAL_THR_RST - 16'd1, 7'd0));
        send_item(make_item(KIND_ACC, 16'h0000, 16'h0000, 16'h0000, 7'd0));
        send_item(make_item(KIND_READ, 16'h0000, 16'h0000, 16'h0000, 7'd90));
        send_item(make_item(KIND_READ, 16'h0000, 16'h0000, 16'h0000, IDX_W'(NBINS - 1)));
        send_item(make_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F));
        send_item(make_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F));
        send_item(make_item(KIND_READ, 16'h0000, 16'h0000, 16'h0000, 7'd90));
        send_item(make_item(KIND_ACC, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd0));
        send_item(make_item(KIND_READ, 16'h0000, 16'h0000, 16'h0000, 7'd90));
    endtask

    // Zero thresholds never divert a pixel; full-scale ones divert all but the top corner.
    task automatic test_threshold_extremes();
        set_thresholds(16'h0000, 16'h0000);
        send_item(make_item(KIND_ACC, 16'h0000, 16'h0000, 16'h0000, 7'd0));
        send_item(make_item(KIND_ACC, 16'hFFFF, 16'h0000, 16'hFFFF, 7'd0));
        set_thresholds(16'hFFFF, 16'hFFFF);
        send_item(make_item(KIND_ACC, 16'h1234, 16'hFFFE, 16'hFFFF, 7'd0));
        send_item(make_item(KIND_ACC, 16'h1234, 16'hFFFF, 16'hFFFE, 7'd0));
        send_item(make_item(KIND_ACC, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd0));
        send_item(make_item(KIND_READ, 16'h0000, 16'h0000, 16'h0000, 7'd99));
    endtask

    // Random traffic under one idle mix; the sender holds off midway until all results are in.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input logic [FRAC_W-1:0] sat_thr,
                                       input logic [FRAC_W-1:0] val_thr);
        set_thresholds(sat_thr, val_thr);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) begin
                wait_results_drained();
            end
            send_item(random_item());
        end
    endtask

    initial begin
        errors        = 0;
        quiet_cycles  = 0;
        src_idle_pct  = 0;
        sink_stall_pct = 0;
        pred_sat_thr  = SAT_THR_RST;
        pred_val_thr  = VAL_THR_RST;
        for (int i = 0; i < NBINS; i++) begin
            hist_count[i] = '0;
            hist_valid[i] = 1'b0;
        end
        last_pixel    = make_item(KIND_ACC, 16'h0000, 16'hFFFF, 16'hFFFF, 7'd0);
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_SAT_THR;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_ACC;
        m_axis_tready <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_threshold_extremes();
        test_random_traffic(0, 0, SAT_THR_RST, VAL_THR_RST);
        test_random_traffic(84, 0, FRAC_W'($urandom_range(20000)),
                            FRAC_W'($urandom_range(20000)));
        test_random_traffic(0, 84, FRAC_W'($urandom_range(20000)),
                            FRAC_W'($urandom_range(20000)));
        test_random_traffic(17, 17, FRAC_W'($urandom_range(20000)),
                            FRAC_W'($urandom_range(20000)));

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
